>>> design/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/jbrq_pkg.sv
// Types and constants of the block requantizer
package jbrq_pkg;
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_SYMBOL  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam int unsigned BLOCK_LEN = 64;
  localparam int unsigned ZRL_RUN = 16;
  localparam logic [11:0] AMP_SAT = 12'd2047;
  localparam logic [3:0] MAX_SIZE = 4'd11;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  component;
    logic [1:0]  table_select;
    logic [3:0]  run_length;
    logic [3:0]  size_class;
    logic [10:0] amplitude_bits;
    logic [5:0]  factor_index;
    logic [15:0] factor_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        is_dc;
    logic [11:0] amplitude_out;
    logic [3:0]  amplitude_length;
    logic        block_done;
    logic        last;
  } out_req_t;
endpackage

>>> design/jpeg_block_requantize_rle.sv
// Top level: JPEG coefficient requantizer and run-length re-encoder
//
// Input channel in_valid/in_stall/in_data carries load, symbol and restart
// requests; out_valid/out_stall/out_data carries re-encoded symbols.
// Factor tables live in one RAM ((2**TAB_W)*64 x 16, registered read).
// A symbol request is taken into a holding register in ST_IDLE, the factor
// RAM is read in ST_READ, the product is formed in ST_MUL, and then the
// 1 to 4 results are sent one per cycle while out_stall is low (ST_EMIT);
// a zero product that does not close the block gives no result. EOB, a
// closing ZRL and a run past the block end skip the RAM and give one result;
// a ZRL that does not close the block, loads and restarts give no result.
// The input is stalled while a symbol is in work, so no new request is taken
// before the last one is through; the single RAM read port and the serial
// emission of ZRL/symbol/EOB results are the reason.
// Reset clears predictors, block position and pending zeros; the factor RAM
// is not cleared and must be loaded before use.
// When out_stall is high in ST_EMIT the current result holds and emission waits.
module jpeg_block_requantize_rle #(
  parameter int NUM_COMPONENTS   = 4,
  parameter int NUM_TABLES       = 4,
  parameter int FACTOR_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jbrq_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jbrq_pkg::out_req_t out_data
);
  import jbrq_pkg::*;
  `include "assert_macros.svh"

  localparam int TAB_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW = TAB_W + 6;
  localparam int DEPTH = (2 ** TAB_W) * BLOCK_LEN;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MUL, ST_EMIT} state_t;
  state_t state_r, state_nxt;

  logic signed [15:0] dpred_r [4];
  logic signed [11:0] epred_r [4];
  logic [6:0] pos_r;
  logic [6:0] pend_r;

  logic [1:0]  comp_r;
  logic        dc_r;
  logic [6:0]  p_r;
  logic [3:0]  run_r;
  logic signed [16:0] val_r;
  logic signed [12:0] sc_r;
  logic [2:0]  nzrl_r;
  logic        emit_eob_r;
  logic        nz_r;
  logic        closes_r;
  logic [6:0]  pendrem_r;

  logic        accept;
  logic [1:0]  comp_sel, tsel_sel;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_rdata;
  logic [1:0]  tsel_r;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    comp_sel = (32'(in_data.component) >= NUM_COMPONENTS) ?
               2'(NUM_COMPONENTS - 1) : in_data.component;
    tsel_sel = (32'(in_data.table_select) >= NUM_TABLES) ?
               2'(NUM_TABLES - 1) : in_data.table_select;
  end

  function automatic logic signed [11:0] dec_amp(input logic [3:0] sz, input logic [10:0] b);
    logic [3:0] s;
    logic [11:0] msk, m;
    s = (sz > MAX_SIZE) ? MAX_SIZE : sz;
    msk = (12'd1 << s) - 12'd1;
    m = {1'b0, b} & msk;
    if (s == 4'd0) dec_amp = '0;
    else if (m[s-4'd1]) dec_amp = m;
    else dec_amp = m - msk;
  endfunction

  function automatic logic [3:0] amp_len(input logic [12:0] a);
    logic [3:0] l;
    l = '0;
    for (int i = 0; i < 13; i++) if (a[i]) l = 4'(i + 1);
    amp_len = l;
  endfunction

  assign ram_we = accept && in_data.kind == KIND_LOAD;
  assign ram_waddr = {TAB_W'(tsel_sel), in_data.factor_index};
  assign ram_raddr = {TAB_W'(tsel_r), p_r[5:0]};

  jbrq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_data.factor_value),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // scale product
  logic [16:0] mag;
  logic [33:0] prod;
  logic [33:0] rnd;
  logic [11:0] psat;
  always_comb begin
    mag = val_r[16] ? 17'(-val_r) : 17'(val_r);
    prod = 34'(mag) * 34'(ram_rdata);
    rnd = (prod + (34'd1 << (FACTOR_FRAC_BITS - 1))) >> FACTOR_FRAC_BITS;
    psat = (rnd > 34'(AMP_SAT)) ? AMP_SAT : rnd[11:0];
  end

  // emission
  logic signed [12:0] ev;
  logic [12:0] eabs;
  logic [3:0] elen;
  logic [11:0] ebits;
  always_comb begin
    ev = dc_r ? (sc_r - 13'(epred_r[comp_r])) : sc_r;
    eabs = ev[12] ? 13'(-ev) : 13'(ev);
    elen = amp_len(eabs);
    ebits = ev[12] ? 12'(ev + 13'((13'd1 << elen) - 13'd1)) : ev[11:0];
  end

  logic more;
  always_comb begin
    more = (nzrl_r != 0) || (nz_r && emit_eob_r);
  end

  logic signed [11:0] damp;
  logic signed [15:0] dsum;
  logic [6:0] pa;
  assign damp = dec_amp(in_data.size_class, in_data.amplitude_bits);
  assign dsum = dpred_r[comp_sel] + 16'(damp);
  assign pa = pos_r + 7'(in_data.run_length);

  out_req_t ob;
  always_comb begin
    ob = '0;
    if (nzrl_r != 0) begin
      ob.symbol = SYM_ZRL;
    end else if (nz_r) begin
      ob.symbol = dc_r ? {4'd0, elen} : {pendrem_r[3:0], elen};
      ob.is_dc = dc_r;
      ob.amplitude_out = ebits;
      ob.amplitude_length = elen;
      ob.block_done = closes_r && !emit_eob_r;
    end else begin
      ob.symbol = SYM_EOB;
      ob.block_done = 1'b1;
    end
    ob.last = !more;
  end

  assign out_valid = (state_r == ST_EMIT);
  assign out_data = ob;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.kind == KIND_SYMBOL) begin
          if (pos_r != 0 && (in_data.size_class == 4'd0 &&
              (in_data.run_length == 4'd0 ||
               (in_data.run_length == 4'd15 && pos_r + 7'd16 >= 7'd64)) ||
              (in_data.size_class != 4'd0 || in_data.run_length != 4'd15) && pa >= 7'd64))
            state_nxt = ST_EMIT;
          else if (!(pos_r != 0 && in_data.run_length == 4'd15 && in_data.size_class == 4'd0))
            state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL: state_nxt = (psat != 0 || dc_r || p_r == 7'd63) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (!out_stall && !more) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      pend_r <= '0;
      for (int i = 0; i < 4; i++) begin
        dpred_r[i] <= '0;
        epred_r[i] <= '0;
      end
      nzrl_r <= '0;
      emit_eob_r <= 1'b0;
      nz_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_data.kind == KIND_RESTART) begin
            for (int i = 0; i < 4; i++) dpred_r[i] <= '0;
            pos_r <= '0;
            pend_r <= '0;
          end else if (accept && in_data.kind == KIND_SYMBOL) begin
            comp_r <= comp_sel;
            tsel_r <= tsel_sel;
            run_r <= in_data.run_length;
            nzrl_r <= '0;
            nz_r <= 1'b0;
            emit_eob_r <= 1'b1;
            if (pos_r == 0) begin
              dc_r <= 1'b1;
              p_r <= '0;
              val_r <= 17'(dsum);
              dpred_r[comp_sel] <= dsum;
            end else begin
              dc_r <= 1'b0;
              p_r <= pa;
              val_r <= 17'(damp);
              if (state_nxt == ST_EMIT) begin
                pos_r <= '0;
                pend_r <= '0;
              end else if (state_nxt == ST_IDLE) begin
                pos_r <= pos_r + 7'd16;
                pend_r <= pend_r + 7'd16;
              end
            end
          end
        end
        ST_READ: ;
        ST_MUL: begin
          sc_r <= val_r[16] ? -13'(psat) : 13'(psat);
          if (dc_r) begin
            nz_r <= 1'b1;
            emit_eob_r <= 1'b0;
            closes_r <= 1'b0;
            pendrem_r <= '0;
            pos_r <= 7'd1;
            pend_r <= '0;
          end else begin
            closes_r <= (p_r == 7'd63);
            if (psat == 0) begin
              nz_r <= 1'b0;
              nzrl_r <= '0;
              pendrem_r <= pend_r + 7'(run_r) + 7'd1;
              emit_eob_r <= 1'b1;
              if (p_r == 7'd63) begin
                pos_r <= '0;
                pend_r <= '0;
              end else begin
                pos_r <= p_r + 7'd1;
                pend_r <= pend_r + 7'(run_r) + 7'd1;
              end
            end else begin
              nz_r <= 1'b1;
              nzrl_r <= 3'((pend_r + 7'(run_r)) >> 4);
              pendrem_r <= 7'((pend_r + 7'(run_r)) & 7'h0F);
              emit_eob_r <= 1'b0;
              pend_r <= '0;
              pos_r <= (p_r == 7'd63) ? 7'd0 : p_r + 7'd1;
            end
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            if (nzrl_r != 0) begin
              nzrl_r <= nzrl_r - 3'd1;
            end else if (nz_r) begin
              nz_r <= 1'b0;
              if (dc_r) epred_r[comp_r] <= 12'(sc_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, accept && state_r != ST_IDLE)
  `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_r > 7'd63)
  `ASSERT_NEVER(a_zrl_count, clk, rst_n, nzrl_r > 3'd3)
  `ASSERT_CLK(a_emit_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
endmodule

>>> design/jbrq_ram.sv
// Generic single-port-write, registered-read RAM
module jbrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> bench/jbrq_checker.sv
// Checker for the block requantizer: predicts re-encoded symbols and compares them
module jbrq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  jbrq_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  jbrq_pkg::out_req_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import jbrq_pkg::*;

  localparam int FRAC = 12;

  logic [15:0] dec_pred [4];
  logic signed [31:0] enc_pred [4];
  logic [15:0] factors [256];
  int unsigned coef_pos;
  int unsigned zero_run;
  out_req_t expected_syms [$];

  assign pending_count = expected_syms.size();

  function automatic int decode_amplitude(logic [3:0] size, logic [10:0] bits);
    int s;
    int m;
    s = (size > MAX_SIZE) ? MAX_SIZE : size;
    if (s == 0) return 0;
    m = bits & ((1 << s) - 1);
    if ((m >> (s - 1)) & 1) return m;
    return m - ((1 << s) - 1);
  endfunction

  function automatic int requantize(int v, logic [15:0] f);
    longint mag;
    longint p;
    mag = (v < 0) ? -v : v;
    p = (mag * f + (64'd1 << (FRAC - 1))) >>> FRAC;
    if (p > AMP_SAT) p = AMP_SAT;
    return (v < 0) ? -int'(p) : int'(p);
  endfunction

  function automatic out_req_t coded_symbol(int v, int run, logic dc);
    out_req_t r;
    int a;
    int s;
    a = (v < 0) ? -v : v;
    s = 0;
    while (s < 13 && (a >> s) != 0) s++;
    r = '0;
    r.amplitude_length = s[3:0];
    r.amplitude_out = (v >= 0) ? v[11:0] : 12'(v + ((1 << s) - 1));
    r.symbol = {run[3:0], s[3:0]};
    r.is_dc = dc;
    return r;
  endfunction

  function automatic out_req_t end_of_block();
    out_req_t r;
    r = '0;
    r.symbol = SYM_EOB;
    r.block_done = 1'b1;
    return r;
  endfunction

  task automatic predict_request(in_req_t q);
    out_req_t res [$];
    out_req_t z;
    int comp;
    int base;
    int p;
    int v;
    int pend;
    int prev;
    int total;
    logic [15:0] sum;
    comp = q.component;
    base = q.table_select * 64;
    if (q.kind == KIND_LOAD) begin
      factors[base + q.factor_index] = q.factor_value;
      return;
    end
    if (q.kind == KIND_RESTART) begin
      foreach (dec_pred[i]) dec_pred[i] = '0;
      coef_pos = 0;
      zero_run = 0;
      return;
    end
    if (q.kind != KIND_SYMBOL) return;
    if (coef_pos == 0) begin
      prev = $signed(dec_pred[comp]);
      total = prev + decode_amplitude(q.size_class, q.amplitude_bits);
      sum = total[15:0];
      v = requantize($signed(sum), factors[base]);
      dec_pred[comp] = sum;
      res.push_back(coded_symbol(v - enc_pred[comp], 0, 1'b1));
      enc_pred[comp] = v;
      coef_pos = 1;
      zero_run = 0;
    end else if (q.run_length == 0 && q.size_class == 0) begin
      res.push_back(end_of_block());
      coef_pos = 0;
      zero_run = 0;
    end else if (q.run_length == 15 && q.size_class == 0) begin
      if (coef_pos + ZRL_RUN >= BLOCK_LEN) begin
        res.push_back(end_of_block());
        coef_pos = 0;
        zero_run = 0;
      end else begin
        coef_pos += ZRL_RUN;
        zero_run += ZRL_RUN;
      end
    end else begin
      p = coef_pos + q.run_length;
      if (p >= BLOCK_LEN) begin
        res.push_back(end_of_block());
        coef_pos = 0;
        zero_run = 0;
      end else begin
        v = requantize(decode_amplitude(q.size_class, q.amplitude_bits), factors[base + p]);
        pend = zero_run + q.run_length;
        if (v == 0) begin
          pend++;
        end else begin
          while (pend > 15) begin
            z = '0;
            z.symbol = SYM_ZRL;
            res.push_back(z);
            pend -= 16;
          end
          res.push_back(coded_symbol(v, pend, 1'b0));
          pend = 0;
        end
        p++;
        if (p >= BLOCK_LEN) begin
          if (pend > 0) res.push_back(end_of_block());
          else res[res.size() - 1].block_done = 1'b1;
          coef_pos = 0;
          zero_run = 0;
        end else begin
          coef_pos = p;
          zero_run = pend & 7'h7F;
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_syms.push_back(res[i]);
  endtask

  task automatic compare_field(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    coef_pos = 0;
    zero_run = 0;
    foreach (dec_pred[i]) dec_pred[i] = '0;
    foreach (enc_pred[i]) enc_pred[i] = 0;
    foreach (factors[i]) factors[i] = '0;
  end

  always @(posedge clk) begin
    out_req_t e;
    if (rst_n && in_valid && !in_stall) predict_request(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_syms.size() == 0) begin
        $error("unexpected result symbol %0h", out_data.symbol);
        fail_count++;
      end else begin
        e = expected_syms.pop_front();
        compare_field("symbol", e.symbol, out_data.symbol);
        compare_field("is_dc", e.is_dc, out_data.is_dc);
        compare_field("amplitude_out", e.amplitude_out, out_data.amplitude_out);
        compare_field("amplitude_length", e.amplitude_length, out_data.amplitude_length);
        compare_field("block_done", e.block_done, out_data.block_done);
        compare_field("last", e.last, out_data.last);
      end
    end
  end
endmodule

>>> bench/jpeg_block_requantize_rle_tb.sv
// Testbench top for the block requantizer: stimulus, stall pattern and verdict
module jpeg_block_requantize_rle_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jbrq_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  in_req_t in_data;
  out_req_t out_data;
  int fail_count;
  int pending_count;
  int cycle_count;
  bit calm;

  jpeg_block_requantize_rle dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  jbrq_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_req_t random_fill();
    in_req_t q;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    q = raw[$bits(in_req_t)-1:0];
    return q;
  endfunction

  task automatic send_request(in_req_t q);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_factor(int tsel, int idx, logic [15:0] f);
    in_req_t q;
    q = random_fill();
    q.kind = KIND_LOAD;
    q.table_select = tsel[1:0];
    q.factor_index = idx[5:0];
    q.factor_value = f;
    send_request(q);
  endtask

  task automatic send_symbol(int run, int size, logic [10:0] bits, int tsel);
    in_req_t q;
    q = random_fill();
    q.kind = KIND_SYMBOL;
    q.table_select = tsel[1:0];
    q.run_length = run[3:0];
    q.size_class = size[3:0];
    q.amplitude_bits = bits;
    send_request(q);
  endtask

  task automatic send_control(logic [1:0] k);
    in_req_t q;
    q = random_fill();
    q.kind = k;
    send_request(q);
  endtask

  function automatic logic [15:0] random_factor();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'h1000;
      default: return 16'($urandom_range(0, 16'h2000));
    endcase
  endfunction

  initial begin
    int tsel;
    int pos;
    int run;
    calm = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int t = 0; t < 2; t++)
      for (int i = 0; i < 64; i++)
        load_factor(t, i, random_factor());

    send_symbol(0, 11, 11'h7FF, 0);
    send_symbol(0, 11, 11'h000, 1);
    send_symbol(15, 0, '0, 1);
    send_symbol(15, 0, '0, 1);
    send_symbol(5, 3, 11'h005, 1);
    send_symbol(3, 0, '0, 1);
    send_symbol(0, 15, 11'h400, 1);
    send_symbol(15, 0, '0, 1);
    send_symbol(15, 0, '0, 1);
    send_symbol(15, 0, '0, 1);
    send_symbol(0, 4, 11'h3, 0);
    send_symbol(15, 11, 11'h7FF, 0);
    send_symbol(0, 1, 11'h1, 1);
    send_symbol(0, 0, '0, 1);
    send_control(KIND_RESTART);
    send_control(KIND_UNUSED);
    load_factor(0, 0, 16'hFFFF);
    send_symbol(0, 11, 11'h400, 0);
    in_valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);

    for (int n = 0; n < 40; n++) begin
      if (n > 32) calm = 1'b1;
      tsel = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: send_control(KIND_RESTART);
        1: load_factor(tsel, $urandom_range(0, 63), random_factor());
        2: send_control(KIND_UNUSED);
        default: begin
          send_symbol(0, $urandom_range(0, 15), 11'($urandom), tsel);
          pos = 1;
          while (pos < 64 && $urandom_range(0, 19) != 0) begin
            run = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(0, 6);
            send_symbol(run, ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 15),
                        11'($urandom), tsel);
            pos += run + 1;
            n++;
          end
          if (n >= 12 && n < 20) begin
            in_valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clk);
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
